// ===== sv/message_fragmenter_trailer_framer_core_assert.svh =====
// assertion macros for the message fragmenter core
// used by the top level only, needs nothing else
`ifndef MESSAGE_FRAGMENTER_TRAILER_FRAMER_CORE_ASSERT_SVH
`define MESSAGE_FRAGMENTER_TRAILER_FRAMER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MFTF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mftf check failed");

// next-cycle implication, checked outside reset
`define MFTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mftf check failed");

`endif

// ===== sv/mftf_pkg.sv =====
// shared types and constants of the message fragmenter
// used by the interfaces, the divider and the top level
`default_nettype none

package mftf_pkg;

  // field widths
  localparam int unsigned PS_W    = 16;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_SIZE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COMPLETE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_CHUNK         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNTED_CHUNK = 2'd3;

  // register reset values
  localparam logic [PS_W-1:0]   RST_PACKET_SIZE = 16'd1024;
  localparam logic [BYTE_W-1:0] RST_TYPE_COMPLETE = 8'd0;
  localparam logic [BYTE_W-1:0] RST_TYPE_CHUNK    = 8'd1;
  localparam logic [BYTE_W-1:0] RST_TYPE_COUNTED  = 8'd2;

  // packet sizing
  localparam logic [PS_W-1:0] MIN_PACKET      = 16'd18;
  localparam logic [PS_W-1:0] COMPLETE_OVH    = 16'd9;
  localparam logic [PS_W-1:0] CHUNK_OVH       = 16'd13;
  localparam logic [PS_W-1:0] COUNTED_OVH     = 16'd17;
  // len + 3 equals (len - first chunk) + (chunk size - 1)
  localparam logic [LEN_W:0]  CEIL_BIAS       = 33'd3;

  // trailer byte positions
  localparam int unsigned TRL_W = 5;
  localparam logic [TRL_W-1:0] TRL_TOTAL = 5'd0;
  localparam logic [TRL_W-1:0] TRL_SEQ   = 5'd4;
  localparam logic [TRL_W-1:0] TRL_ID    = 5'd8;
  localparam logic [TRL_W-1:0] TRL_TYPE  = 5'd16;

  // shared divider
  localparam int unsigned DIV_NUM_W = LEN_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(DIV_NUM_W - 1);

  typedef enum logic [1:0] {
    KIND_COMPLETE = 2'd0,
    KIND_CHUNK    = 2'd1,
    KIND_COUNTED  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  // first trailer byte position for a packet kind
  function automatic logic [TRL_W-1:0] trl_start(input kind_t kind);
    logic [TRL_W-1:0] pos;
    unique case (kind)
      KIND_COUNTED: pos = TRL_TOTAL;
      KIND_CHUNK:   pos = TRL_SEQ;
      default:      pos = TRL_ID;
    endcase
    return pos;
  endfunction

  // packet size with the lower bound applied
  function automatic logic [PS_W-1:0] eff_size(input logic [PS_W-1:0] ps);
    return (ps < MIN_PACKET) ? MIN_PACKET : ps;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mftf_in_if.sv =====
// input channel of the message fragmenter: one payload byte per item
// depends on mftf_pkg for widths
`default_nettype none

interface mftf_in_if;
  logic                           valid;
  logic                           ready;
  logic [mftf_pkg::BYTE_W-1:0]    data_byte;
  logic [mftf_pkg::LEN_W-1:0]     msg_length;
  logic                           first_of_message;

  modport source (output valid, output data_byte, output msg_length,
                  output first_of_message, input ready);
  modport sink   (input valid, input data_byte, input msg_length,
                  input first_of_message, output ready);
endinterface

`default_nettype wire

// ===== sv/mftf_out_if.sv =====
// output channel of the message fragmenter: one serialized byte per item
// depends on mftf_pkg for widths
`default_nettype none

interface mftf_out_if;
  logic                           valid;
  logic                           ready;
  logic [mftf_pkg::BYTE_W-1:0]    out_byte;
  logic                           end_of_packet;
  logic                           end_of_message;

  modport source (output valid, output out_byte, output end_of_packet,
                  output end_of_message, input ready);
  modport sink   (input valid, input out_byte, input end_of_packet,
                  input end_of_message, output ready);
endinterface

`default_nettype wire

// ===== sv/mftf_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on mftf_pkg for widths and step count
`default_nettype none

module mftf_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [mftf_pkg::DIV_NUM_W-1:0]    num,
  input  wire logic [mftf_pkg::PS_W-1:0]         den,
  output logic                                   done,
  output logic [mftf_pkg::CNT_W-1:0]             quo
);

  logic                              busy;
  logic [mftf_pkg::DIV_CNT_W-1:0]    step;
  logic [mftf_pkg::PS_W-1:0]         rem;
  logic [mftf_pkg::PS_W-1:0]         dvs;
  logic [mftf_pkg::DIV_NUM_W-1:0]    qn;
  logic [mftf_pkg::PS_W:0]           trial;
  logic                              fits;

  // one trial subtract per cycle
  assign trial = {rem, qn[mftf_pkg::DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == mftf_pkg::DIV_LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == mftf_pkg::DIV_LAST_STEP) begin
          busy <= 1'b0;
        end
        step <= step + 1'b1;
      end
    end
  end

  // datapath, numerator shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= den;
      qn  <= num;
    end else if (busy) begin
      rem <= fits ? mftf_pkg::PS_W'(trial - {1'b0, dvs}) : trial[mftf_pkg::PS_W-1:0];
      qn  <= {qn[mftf_pkg::DIV_NUM_W-2:0], fits};
    end
  end

  // quotient of len+3 by a divisor of at least 5 fits 32 bits
  assign quo = qn[mftf_pkg::CNT_W-1:0];

endmodule

`default_nettype wire

// ===== sv/message_fragmenter_trailer_framer_core.sv =====
// message fragmenter core: a payload byte item appears on the output in the cycle after it is taken
// a byte closing a packet is followed by its 9, 13 or 17 byte trailer, one per cycle unless stalled
// after the first byte of a message longer than one packet, input waits on the packet count divider
// otherwise one item per cycle while the output is drained; stalls hold in the output register
// synchronous active-high reset clears all control state, id counter and config registers to defaults
`default_nettype none

`include "message_fragmenter_trailer_framer_core_assert.svh"

module message_fragmenter_trailer_framer_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  mftf_in_if.sink                                msg,
  mftf_out_if.source                             pkt,
  input  wire logic                              cfg_we,
  input  wire logic [mftf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mftf_pkg::PS_W-1:0]         cfg_data
);

  // configuration registers
  logic [mftf_pkg::PS_W-1:0]    max_pkt_len;
  logic [mftf_pkg::BYTE_W-1:0]  type_code_complete;
  logic [mftf_pkg::BYTE_W-1:0]  type_code_chunk;
  logic [mftf_pkg::BYTE_W-1:0]  type_code_counted_chunk;

  // framing state
  mftf_pkg::state_t             st, st_next;
  mftf_pkg::kind_t              kind, kind_next;
  logic [mftf_pkg::ID_W-1:0]    id_ctr, id_ctr_next;
  logic [mftf_pkg::ID_W-1:0]    cur_id, cur_id_next;
  logic [mftf_pkg::LEN_W-1:0]   blm, blm_next;
  logic [mftf_pkg::PS_W-1:0]    blp, blp_next;
  logic [mftf_pkg::CNT_W-1:0]   seq, seq_next;
  logic [mftf_pkg::CNT_W-1:0]   total, total_next;
  logic [mftf_pkg::TRL_W-1:0]   trl_idx, trl_idx_next;
  logic                         trl_pend, trl_pend_next;

  // output register
  logic                         out_valid, out_valid_next;
  logic [mftf_pkg::BYTE_W-1:0]  out_byte, out_byte_next;
  logic                         out_eop, out_eop_next;
  logic                         out_eom, out_eom_next;

  // helpers
  logic                         slot_free;
  logic                         accept;
  logic [mftf_pkg::PS_W-1:0]    ps_eff;
  logic                         is_short;
  mftf_pkg::kind_t              kind_new;
  logic [mftf_pkg::LEN_W-1:0]   blm_base;
  logic [mftf_pkg::PS_W-1:0]    blp_base;
  logic [mftf_pkg::LEN_W-1:0]   blm_dec;
  logic [mftf_pkg::PS_W-1:0]    blp_dec;
  logic [mftf_pkg::PS_W-1:0]    chunk_sz;
  logic [mftf_pkg::BYTE_W-1:0]  trl_byte;
  logic [mftf_pkg::BYTE_W-1:0]  type_code;
  logic                         div_start;
  logic                         div_done;
  logic [mftf_pkg::CNT_W-1:0]   div_quo;

  assign slot_free = !out_valid || pkt.ready;
  assign msg.ready = (st == mftf_pkg::ST_IDLE) && slot_free;
  assign accept    = msg.valid && msg.ready;

  assign pkt.valid          = out_valid;
  assign pkt.out_byte       = out_byte;
  assign pkt.end_of_packet  = out_eop;
  assign pkt.end_of_message = out_eom;

  // sizing of a new message and the byte it carries
  assign ps_eff   = mftf_pkg::eff_size(max_pkt_len);
  assign chunk_sz = ps_eff - mftf_pkg::CHUNK_OVH;
  assign is_short = msg.msg_length <=
                    mftf_pkg::LEN_W'(ps_eff - mftf_pkg::COMPLETE_OVH);
  assign kind_new = !msg.first_of_message ? kind :
                    is_short ? mftf_pkg::KIND_COMPLETE : mftf_pkg::KIND_COUNTED;
  assign blm_base = msg.first_of_message ? msg.msg_length : blm;
  assign blp_base = !msg.first_of_message ? blp :
                    is_short ? msg.msg_length[mftf_pkg::PS_W-1:0] :
                    ps_eff - mftf_pkg::COUNTED_OVH;
  assign blm_dec  = blm_base - 1'b1;
  assign blp_dec  = (blp_base != '0) ? blp_base - 1'b1 : '0;

  // trailer byte at the current position
  always_comb begin
    unique case (kind)
      mftf_pkg::KIND_COUNTED: type_code = type_code_counted_chunk;
      mftf_pkg::KIND_CHUNK:   type_code = type_code_chunk;
      default:                type_code = type_code_complete;
    endcase
    if (trl_idx[4]) begin
      trl_byte = type_code;
    end else if (trl_idx[3]) begin
      trl_byte = cur_id[{trl_idx[2:0], 3'b000} +: mftf_pkg::BYTE_W];
    end else if (trl_idx[2]) begin
      trl_byte = seq[{trl_idx[1:0], 3'b000} +: mftf_pkg::BYTE_W];
    end else begin
      trl_byte = total[{trl_idx[1:0], 3'b000} +: mftf_pkg::BYTE_W];
    end
  end

  // packet count divider, ceil division folded into the numerator
  mftf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mftf_pkg::DIV_NUM_W'(msg.msg_length) + mftf_pkg::CEIL_BIAS),
    .den   (chunk_sz),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer: next state and outputs
  always_comb begin
    st_next        = st;
    kind_next      = kind;
    id_ctr_next    = id_ctr;
    cur_id_next    = cur_id;
    blm_next       = blm;
    blp_next       = blp;
    seq_next       = seq;
    total_next     = total;
    trl_idx_next   = trl_idx;
    trl_pend_next  = trl_pend;
    out_valid_next = out_valid && !pkt.ready;
    out_byte_next  = out_byte;
    out_eop_next   = out_eop;
    out_eom_next   = out_eom;
    div_start      = 1'b0;
    unique case (st)
      mftf_pkg::ST_IDLE: begin
        if (accept) begin
          if (msg.first_of_message) begin
            cur_id_next = id_ctr;
            id_ctr_next = id_ctr + 1'b1;
            seq_next    = '0;
            kind_next   = kind_new;
            if (is_short) begin
              total_next = mftf_pkg::CNT_W'(1);
            end
          end
          trl_idx_next = mftf_pkg::trl_start(kind_new);
          priority if (msg.first_of_message && msg.msg_length == '0) begin
            // empty message: trailer only
            blm_next = '0;
            blp_next = '0;
            st_next  = mftf_pkg::ST_EMIT;
          end else if (!msg.first_of_message && blm == '0) begin
            // byte outside a message is dropped
            trl_idx_next = trl_idx;
          end else begin
            out_valid_next = 1'b1;
            out_byte_next  = msg.data_byte;
            out_eop_next   = 1'b0;
            out_eom_next   = 1'b0;
            blm_next       = blm_dec;
            blp_next       = blp_dec;
            trl_pend_next  = (blp_dec == '0) || (blm_dec == '0);
            if (msg.first_of_message && !is_short) begin
              div_start = 1'b1;
              st_next   = mftf_pkg::ST_DIV;
            end else if ((blp_dec == '0) || (blm_dec == '0)) begin
              st_next = mftf_pkg::ST_EMIT;
            end
          end
        end
      end
      mftf_pkg::ST_DIV: begin
        if (div_done) begin
          total_next = div_quo + 1'b1;
          st_next    = trl_pend ? mftf_pkg::ST_EMIT : mftf_pkg::ST_IDLE;
        end
      end
      mftf_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = trl_byte;
          out_eop_next   = trl_idx == mftf_pkg::TRL_TYPE;
          out_eom_next   = (trl_idx == mftf_pkg::TRL_TYPE) && (blm == '0);
          if (trl_idx == mftf_pkg::TRL_TYPE) begin
            // size the next packet of this message
            st_next       = mftf_pkg::ST_IDLE;
            trl_pend_next = 1'b0;
            if (blm != '0) begin
              seq_next  = seq + 1'b1;
              kind_next = mftf_pkg::KIND_CHUNK;
              blp_next  = (blm < mftf_pkg::LEN_W'(chunk_sz)) ?
                          blm[mftf_pkg::PS_W-1:0] : chunk_sz;
            end else begin
              blp_next = '0;
            end
          end else begin
            trl_idx_next = trl_idx + 1'b1;
          end
        end
      end
      default: begin
        st_next = mftf_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_pkt_len             <= mftf_pkg::RST_PACKET_SIZE;
      type_code_complete      <= mftf_pkg::RST_TYPE_COMPLETE;
      type_code_chunk         <= mftf_pkg::RST_TYPE_CHUNK;
      type_code_counted_chunk <= mftf_pkg::RST_TYPE_COUNTED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mftf_pkg::CFG_PACKET_SIZE:        max_pkt_len <= cfg_data;
        mftf_pkg::CFG_TYPE_COMPLETE:      type_code_complete <= cfg_data[7:0];
        mftf_pkg::CFG_TYPE_CHUNK:         type_code_chunk <= cfg_data[7:0];
        mftf_pkg::CFG_TYPE_COUNTED_CHUNK: type_code_counted_chunk <= cfg_data[7:0];
        default:                          max_pkt_len <= max_pkt_len;
      endcase
    end
  end

  // control and framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= mftf_pkg::ST_IDLE;
      kind      <= mftf_pkg::KIND_COMPLETE;
      id_ctr    <= '0;
      cur_id    <= '0;
      blm       <= '0;
      blp       <= '0;
      seq       <= '0;
      total     <= '0;
      trl_idx   <= '0;
      trl_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st        <= st_next;
      kind      <= kind_next;
      id_ctr    <= id_ctr_next;
      cur_id    <= cur_id_next;
      blm       <= blm_next;
      blp       <= blp_next;
      seq       <= seq_next;
      total     <= total_next;
      trl_idx   <= trl_idx_next;
      trl_pend  <= trl_pend_next;
      out_valid <= out_valid_next;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_byte <= out_byte_next;
    out_eop  <= out_eop_next;
    out_eom  <= out_eom_next;
  end

  // checks
  `MFTF_ASSERT_NOW(a_busy_not_ready, clk, rst, st != mftf_pkg::ST_IDLE, !msg.ready)
  `MFTF_ASSERT_NOW(a_div_done_in_div, clk, rst, div_done, st == mftf_pkg::ST_DIV)
  `MFTF_ASSERT_NOW(a_trl_idx_range, clk, rst, st == mftf_pkg::ST_EMIT,
                   trl_idx <= mftf_pkg::TRL_TYPE)
  `MFTF_ASSERT_NOW(a_eom_on_eop, clk, rst, out_valid && out_eom, out_eop)
  `MFTF_ASSERT_NEXT(a_empty_goes_emit, clk, rst,
                    accept && msg.first_of_message && msg.msg_length == '0,
                    st == mftf_pkg::ST_EMIT)

endmodule

`default_nettype wire

// ===== tb/tb_message_fragmenter_trailer_framer_core.sv =====
// self-checking testbench for the message fragmenter core: drives payload byte items,
// predicts the serialized packet bytes with trailers and checks every output item
// depends on mftf_pkg, mftf_in_if, mftf_out_if and the core itself
`default_nettype none

module tb_message_fragmenter_trailer_framer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 220;
  localparam int PHASE_ITEMS   = 40;
  localparam int SETTLE_CYCLES = 60;
  localparam int QUIET_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [mftf_pkg::BYTE_W-1:0] data;
    logic                        eop;
    logic                        eom;
  } link_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                           cfg_we;
  logic [mftf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mftf_pkg::PS_W-1:0]      cfg_data;

  mftf_in_if  msg ();
  mftf_out_if pkt ();

  message_fragmenter_trailer_framer_core dut (
    .clk       (clk),
    .rst       (rst),
    .msg       (msg),
    .pkt       (pkt),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // framer state mirrored by the predictor
  logic [mftf_pkg::PS_W-1:0]   size_reg;
  logic [mftf_pkg::BYTE_W-1:0] code_whole;
  logic [mftf_pkg::BYTE_W-1:0] code_chunk;
  logic [mftf_pkg::BYTE_W-1:0] code_counted;
  logic [mftf_pkg::ID_W-1:0]   id_next;
  logic [mftf_pkg::ID_W-1:0]   id_cur;
  logic [mftf_pkg::LEN_W-1:0]  msg_left;
  logic [mftf_pkg::PS_W-1:0]   pkt_left;
  logic [mftf_pkg::CNT_W-1:0]  seq_cur;
  logic [mftf_pkg::CNT_W-1:0]  pkt_total;
  mftf_pkg::kind_t             kind_cur;

  // serialized bytes still owed by the block, oldest first
  link_byte_t pending_bytes[$];

  int payload_items = 0;
  int ignored_items = 0;
  int bytes_seen    = 0;
  int packets_seen  = 0;
  int messages_seen = 0;
  int mismatches    = 0;
  int sink_hold     = 0;
  int quiet_cycles  = 0;
  bit calm          = 1'b0;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  function automatic int psize_eff();
    return (size_reg < mftf_pkg::MIN_PACKET) ? int'(mftf_pkg::MIN_PACKET) : int'(size_reg);
  endfunction

  function automatic void push_byte(logic [mftf_pkg::BYTE_W-1:0] b, logic eop, logic eom);
    pending_bytes.insert(pending_bytes.size(), link_byte_t'{data: b, eop: eop, eom: eom});
  endfunction

  // little-endian field, lowest byte first
  function automatic void push_le(logic [63:0] v, int nbytes);
    int i;
    for (i = 0; i < nbytes; i++) push_byte(v[8*i +: 8], 1'b0, 1'b0);
  endfunction

  function automatic void push_trailer();
    logic                        last;
    logic [mftf_pkg::BYTE_W-1:0] code;
    last = (msg_left == 0);
    case (kind_cur)
      mftf_pkg::KIND_COUNTED: begin
        push_le(64'(pkt_total), 4);
        push_le(64'(seq_cur), 4);
        code = code_counted;
      end
      mftf_pkg::KIND_CHUNK: begin
        push_le(64'(seq_cur), 4);
        code = code_chunk;
      end
      default: code = code_whole;
    endcase
    push_le(id_cur, 8);
    push_byte(code, 1'b1, last);
  endfunction

  // expected output bytes for one accepted input item, returns how many
  function automatic int frame_message_byte(logic [mftf_pkg::BYTE_W-1:0] data,
                                            logic [mftf_pkg::LEN_W-1:0] len, logic first);
    longint unsigned ps;
    longint unsigned head_sz;
    longint unsigned body_sz;
    longint unsigned rest;
    longint unsigned count;
    int              queued_at_start;
    queued_at_start = pending_bytes.size();
    ps = longint'(psize_eff());
    if (first) begin
      id_cur = id_next;
      id_next++;
      msg_left = len;
      seq_cur = '0;
      if (longint'(len) <= ps - mftf_pkg::COMPLETE_OVH) begin
        kind_cur = mftf_pkg::KIND_COMPLETE;
        pkt_left = mftf_pkg::PS_W'(len);
        pkt_total = 1;
      end else begin
        head_sz = ps - mftf_pkg::COUNTED_OVH;
        body_sz = ps - mftf_pkg::CHUNK_OVH;
        rest = longint'(len) - head_sz;
        count = 1 + (rest + body_sz - 1) / body_sz;
        kind_cur = mftf_pkg::KIND_COUNTED;
        pkt_left = mftf_pkg::PS_W'(head_sz);
        pkt_total = mftf_pkg::CNT_W'(count);
      end
      // empty message: trailer only
      if (len == 0) begin
        push_trailer();
        return pending_bytes.size() - queued_at_start;
      end
    end else if (msg_left == 0) begin
      return 0;
    end
    push_byte(data, 1'b0, 1'b0);
    msg_left--;
    if (pkt_left != 0) pkt_left--;
    if (pkt_left == 0 || msg_left == 0) begin
      push_trailer();
      if (msg_left != 0) begin
        seq_cur++;
        kind_cur = mftf_pkg::KIND_CHUNK;
        pkt_left = (longint'(msg_left) < ps - mftf_pkg::CHUNK_OVH) ?
                   mftf_pkg::PS_W'(msg_left) : mftf_pkg::PS_W'(ps - mftf_pkg::CHUNK_OVH);
      end else begin
        pkt_left = '0;
      end
    end
    return pending_bytes.size() - queued_at_start;
  endfunction

  task automatic reset_model();
    size_reg = mftf_pkg::RST_PACKET_SIZE;
    code_whole = mftf_pkg::RST_TYPE_COMPLETE;
    code_chunk = mftf_pkg::RST_TYPE_CHUNK;
    code_counted = mftf_pkg::RST_TYPE_COUNTED;
    id_next = '0;
    id_cur = '0;
    msg_left = '0;
    pkt_left = '0;
    seq_cur = '0;
    pkt_total = '0;
    kind_cur = mftf_pkg::KIND_COMPLETE;
  endtask

  // one input item, valid stays high when the next item follows at once
  task automatic send_item(input logic [mftf_pkg::BYTE_W-1:0] data,
                           input logic [mftf_pkg::LEN_W-1:0] len, input logic first);
    int gap;
    int n;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      msg.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg.valid <= 1'b1;
    msg.data_byte <= data;
    msg.msg_length <= len;
    msg.first_of_message <= first;
    do @(posedge clk); while (!msg.ready);
    n = frame_message_byte(data, len, first);
    if (n == 0) ignored_items++;
    else payload_items++;
  endtask

  // hold off until every owed byte is out, then let the core go quiet
  task automatic settle();
    msg.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers back to back, type codes with junk upper bits
  task automatic program_regs(input logic [mftf_pkg::PS_W-1:0] new_size,
                              input logic [7:0] c_whole, input logic [7:0] c_chunk,
                              input logic [7:0] c_counted);
    cfg_we <= 1'b1;
    cfg_index <= mftf_pkg::CFG_PACKET_SIZE;
    cfg_data <= new_size;
    @(posedge clk);
    cfg_index <= mftf_pkg::CFG_TYPE_COMPLETE;
    cfg_data <= {8'($urandom), c_whole};
    @(posedge clk);
    cfg_index <= mftf_pkg::CFG_TYPE_CHUNK;
    cfg_data <= {8'($urandom), c_chunk};
    @(posedge clk);
    cfg_index <= mftf_pkg::CFG_TYPE_COUNTED_CHUNK;
    cfg_data <= {8'($urandom), c_counted};
    @(posedge clk);
    cfg_we <= 1'b0;
    size_reg = new_size;
    code_whole = c_whole;
    code_chunk = c_chunk;
    code_counted = c_counted;
  endtask

  // reset settings: empty message, short message, stray item outside a message
  task automatic test_defaults();
    send_item(8'hA5, 32'd0, 1'b1);
    send_item(8'h00, 32'd2, 1'b1);
    send_item(8'hFF, 32'd2, 1'b0);
    send_item(8'h3C, 32'hFFFF_FFFF, 1'b0);
    settle();
  endtask

  // packet size below the floor acts as 18: counted chunk of 1, chunks of 5
  task automatic test_minimum_packet();
    int i;
    program_regs(16'd0, 8'hFF, 8'h00, 8'h80);
    for (i = 0; i < 12; i++) send_item(i[0] ? 8'hFF : 8'h00, 32'd12, i == 0);
    settle();
  endtask

  // messages cut short by a new first item, huge length, largest packet size
  task automatic test_dropped_messages();
    program_regs(16'd17, 8'h5A, 8'hA5, 8'hFF);
    send_item(8'h81, 32'hFFFF_FFFF, 1'b1);
    send_item(8'h7E, 32'hFFFF_FFFF, 1'b0);
    send_item(8'hC3, 32'd1, 1'b1);
    settle();
    program_regs(16'hFFFF, 8'h5A, 8'hA5, 8'hFF);
    send_item(8'h11, 32'd65527, 1'b1);
    send_item(8'h22, 32'd0, 1'b1);
    settle();
  endtask

  // packet size shrinks between chunks of one message
  task automatic test_resize_mid_message();
    int i;
    program_regs(16'd19, 8'h01, 8'h02, 8'h03);
    for (i = 0; i < 3; i++) send_item(8'($urandom), 32'd12, i == 0);
    settle();
    program_regs(16'd18, 8'h01, 8'h02, 8'h03);
    for (i = 0; i < 9; i++) send_item(8'($urandom), 32'd12, 1'b0);
    settle();
  endtask

  // one message with random length and content, sometimes cut, sometimes a stray item
  task automatic send_random_message();
    int                         ps;
    int                         max_len;
    int                         nbytes;
    int                         r;
    int                         i;
    logic [mftf_pkg::LEN_W-1:0] len;
    logic [mftf_pkg::LEN_W-1:0] field;
    bit                         cut;
    ps = psize_eff();
    max_len = (ps <= 64) ? 3 * ps : 40;
    r = $urandom_range(0, 99);
    if (r < 6) len = 0;
    else if (r < 14) len = $urandom;
    else if (r < 26) len = ps - 9 + $urandom_range(0, 1);
    else if (r < 34) len = ps - 17 + (ps - 13) * $urandom_range(0, 2) + $urandom_range(0, 1);
    else len = $urandom_range(1, max_len);
    cut = ($urandom_range(0, 9) == 0);
    if (len == 0) nbytes = 1;
    else if (len > max_len || cut) nbytes = $urandom_range(1, (len < 6) ? len : 6);
    else nbytes = len;
    for (i = 0; i < nbytes; i++) begin
      field = (i == 0 || $urandom_range(0, 9) != 0) ? len : $urandom;
      send_item(8'($urandom), field, i == 0);
    end
    if ($urandom_range(0, 11) == 0) send_item(8'($urandom), $urandom, 1'b0);
  endtask

  // phases of random traffic, each under a fresh register setting
  task automatic test_random_traffic();
    int                        target;
    int                        phase_end;
    logic [mftf_pkg::PS_W-1:0] ps;
    target = payload_items + RANDOM_ITEMS;
    while (payload_items < target) begin
      case ($urandom_range(0, 9))
        0: ps = mftf_pkg::PS_W'($urandom_range(0, 17));
        1: ps = 16'hFFFF;
        2: ps = mftf_pkg::MIN_PACKET;
        default: ps = mftf_pkg::PS_W'($urandom_range(19, 64));
      endcase
      calm = ($urandom_range(0, 3) == 0);
      program_regs(ps, 8'($urandom), 8'($urandom), 8'($urandom));
      phase_end = payload_items + PHASE_ITEMS;
      while (payload_items < phase_end && payload_items < target) send_random_message();
      settle();
    end
    calm = 1'b0;
  endtask

  // compare one output item with the oldest owed byte
  function automatic void check_result();
    link_byte_t seen;
    link_byte_t due;
    seen = link_byte_t'{data: pkt.out_byte, eop: pkt.end_of_packet, eom: pkt.end_of_message};
    bytes_seen++;
    if (seen.eop === 1'b1) packets_seen++;
    if (seen.eom === 1'b1) messages_seen++;
    if (pending_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: unexpected output byte %02h eop %b eom %b", $realtime,
                 seen.data, seen.eop, seen.eom);
      return;
    end
    due = pending_bytes.pop_front();
    if (seen.data !== due.data || seen.eop !== due.eop || seen.eom !== due.eom) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: output byte %0d expected %02h eop %b eom %b, got %02h eop %b eom %b",
                 $realtime, bytes_seen, due.data, due.eop, due.eom,
                 seen.data, seen.eop, seen.eom);
    end
  endfunction

  // output side: check accepted items, stall at random
  always @(posedge clk) begin
    if (rst) begin
      pkt.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (pkt.valid && pkt.ready) check_result();
      if (calm) begin
        pkt.ready <= 1'b1;
      end else if (sink_hold > 0) begin
        pkt.ready <= 1'b0;
        sink_hold = sink_hold - 1;
      end else begin
        pkt.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) sink_hold = pick_gap();
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (msg.valid && msg.ready) || (pkt.valid && pkt.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset, then the tests in turn
  initial begin
    msg.valid <= 1'b0;
    msg.data_byte <= '0;
    msg.msg_length <= '0;
    msg.first_of_message <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= mftf_pkg::CFG_PACKET_SIZE;
    cfg_data <= '0;
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_minimum_packet();
    test_dropped_messages();
    test_resize_mid_message();
    test_random_traffic();
    settle();

    $display("covered %0d payload items and %0d stray items, directed and random",
             payload_items, ignored_items);
    $display("checked %0d output bytes in %0d packets, %0d messages closed, %0d mismatches",
             bytes_seen, packets_seen, messages_seen, mismatches);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
